### hdl/dtw_pkg.sv
// Shared types, constants and the template table for the gesture matcher
`timescale 1ns / 1ps
package dtw_pkg;
    localparam int NCH      = 10;
    localparam int COST_W   = 24;
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
    localparam logic [23:0] THR_RESET = 24'd6400;
    localparam int BUILTIN  = 3;
    localparam logic [7:0] CODE_NONE  = 8'd78;
    localparam logic [7:0] CODE_L     = 8'd76;
    localparam logic [7:0] CODE_EXTRA = 8'd63;
    localparam int SUMSQ_W  = 38;

    typedef logic signed [15:0] sample_t;
    typedef sample_t [NCH-1:0] vec_t;

    // queued work: one sample and its end marker
    typedef struct packed {
        vec_t samp;
        logic last;
    } work_t;

    typedef enum logic [2:0] {
        B_IDLE, B_DIFF, B_SQRT, B_UPD, B_SCAN, B_OUT
    } bstate_t;

    typedef enum logic [1:0] {
        REG_THR_A = 2'd0,
        REG_THR_B = 2'd1,
        REG_THR_C = 2'd2
    } reg_idx_t;

    // Built-in templates, Q8.8; entries outside the table read as zero
    function automatic logic signed [15:0] tmpl_val(input int t, input int n, input int c);
        logic signed [15:0] tab [0:89];
        tab = '{
            -16'sd146, -16'sd100, 16'sd335, -16'sd302, -16'sd225, 16'sd750, 16'sd484,
            16'sd428, 16'sd397, 16'sd410,
            16'sd54, -16'sd246, 16'sd90, 16'sd125, -16'sd558, 16'sd207, 16'sd489,
            16'sd425, 16'sd384, 16'sd399,
            16'sd46, -16'sd238, 16'sd110, 16'sd105, -16'sd550, 16'sd253, 16'sd484,
            16'sd425, 16'sd402, 16'sd412,
            -16'sd151, -16'sd233, 16'sd353, -16'sd340, -16'sd532, 16'sd776, 16'sd492,
            16'sd420, 16'sd387, 16'sd420,
            16'sd67, -16'sd238, 16'sd84, 16'sd151, -16'sd556, 16'sd200, 16'sd497,
            16'sd443, 16'sd394, 16'sd397,
            16'sd69, -16'sd243, 16'sd84, 16'sd159, -16'sd558, 16'sd195, 16'sd497,
            16'sd430, 16'sd407, 16'sd399,
            -16'sd128, -16'sd261, 16'sd148, -16'sd297, -16'sd653, 16'sd387, 16'sd494,
            16'sd440, 16'sd387, 16'sd399,
            16'sd61, -16'sd212, 16'sd90, 16'sd141, -16'sd481, 16'sd207, 16'sd499,
            16'sd425, 16'sd404, 16'sd412,
            16'sd59, -16'sd238, 16'sd90, 16'sd136, -16'sd540, 16'sd200, 16'sd486,
            16'sd433, 16'sd410, 16'sd397};
        if (t < BUILTIN && n < BUILTIN && c < NCH)
            return tab[(t * BUILTIN + n) * NCH + c];
        return 16'sd0;
    endfunction
endpackage

### hdl/dtw_gesture_matcher.sv
// Top level of the DTW gesture matcher
`timescale 1ns / 1ps
// A sample is taken when start is high and busy is low; up to two samples queue
// ahead of the compute engine. Each of the NUM_TEMPLATES*TEMPLATE_LEN cells takes
// a squared-difference accumulation over the channels, a bit-pair square root and
// one column update; a sample that arrives past MAX_SAMPLES is not scored. The last
// sample adds a scan over the cells that stops once a match is found, and then the
// result. The result appears for one cycle with done high and must be taken then,
// as the receiver cannot stall it.
module dtw_gesture_matcher #(
    parameter int NUM_TEMPLATES = 3,
    parameter int TEMPLATE_LEN  = 3,
    parameter int MAX_SAMPLES   = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [15:0]  imu_ch0,
    input  logic [15:0]  imu_ch1,
    input  logic [15:0]  imu_ch2,
    input  logic [15:0]  imu_ch6,
    input  logic [15:0]  imu_ch7,
    input  logic [15:0]  imu_ch8,
    input  logic [15:0]  imu_ch9,
    input  logic [15:0]  imu_ch10,
    input  logic [15:0]  imu_ch11,
    input  logic [15:0]  imu_ch12,
    input  logic         last_sample,
    output logic         done,
    output logic         gesture_found,
    output logic [1:0]   template_index,
    output logic [7:0]   gesture_code,
    output logic [23:0]  best_score,
    output logic         sample_overflow,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import dtw_pkg::*;

    vec_t samp;
    work_t q_data;
    logic q_valid, q_pop;
    logic [23:0] thr_a, thr_b, thr_c;

    assign samp = {imu_ch12, imu_ch11, imu_ch10, imu_ch9, imu_ch8,
                   imu_ch7, imu_ch6, imu_ch2, imu_ch1, imu_ch0};
    assign pready = 1'b1;

    dtw_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .samp(samp),
        .last_sample(last_sample), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .thr_a(thr_a), .thr_b(thr_b), .thr_c(thr_c),
        .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
    );

    dtw_back #(
        .NUM_TEMPLATES(NUM_TEMPLATES), .TEMPLATE_LEN(TEMPLATE_LEN),
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
        .thr_a(thr_a), .thr_b(thr_b), .thr_c(thr_c), .done(done),
        .gesture_found(gesture_found), .template_index(template_index),
        .gesture_code(gesture_code), .best_score(best_score),
        .sample_overflow(sample_overflow)
    );
endmodule

### hdl/dtw_front.sv
// Front end: takes samples, holds thresholds, queues work for the back end
`timescale 1ns / 1ps
module dtw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  dtw_pkg::vec_t        samp,
    input  logic                 last_sample,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic [23:0]          thr_a,
    output logic [23:0]          thr_b,
    output logic [23:0]          thr_c,
    output logic                 q_valid,
    output dtw_pkg::work_t       q_data,
    input  logic                 q_pop
);
    import dtw_pkg::*;

    // two-entry queue
    work_t     q_mem [0:1];
    logic      wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic [23:0] thr_a_reg, thr_b_reg, thr_c_reg;
    logic push;
    reg_idx_t idx;

    assign busy    = (cnt_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = q_mem[rp_reg];
    assign idx     = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wp_reg] <= '{samp: samp, last: last_sample};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (q_pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    // threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_a_reg <= THR_RESET;
            thr_b_reg <= THR_RESET;
            thr_c_reg <= THR_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                REG_THR_A: thr_a_reg <= pwdata[23:0];
                REG_THR_B: thr_b_reg <= pwdata[23:0];
                REG_THR_C: thr_c_reg <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_THR_A: prdata = {8'd0, thr_a_reg};
            REG_THR_B: prdata = {8'd0, thr_b_reg};
            REG_THR_C: prdata = {8'd0, thr_c_reg};
            default:   prdata = 32'd0;
        endcase
    end

    assign thr_a = thr_a_reg;
    assign thr_b = thr_b_reg;
    assign thr_c = thr_c_reg;
endmodule

### hdl/dtw_back.sv
// Back end: per-cell distance, iterative square root, column update and final scan
`timescale 1ns / 1ps
module dtw_back #(
    parameter int NUM_TEMPLATES = 3,
    parameter int TEMPLATE_LEN  = 3,
    parameter int MAX_SAMPLES   = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  dtw_pkg::work_t q_data,
    output logic           q_pop,
    input  logic [23:0]    thr_a,
    input  logic [23:0]    thr_b,
    input  logic [23:0]    thr_c,
    output logic           done,
    output logic           gesture_found,
    output logic [1:0]     template_index,
    output logic [7:0]     gesture_code,
    output logic [23:0]    best_score,
    output logic           sample_overflow
);
    import dtw_pkg::*;

    localparam int NCELL  = NUM_TEMPLATES * TEMPLATE_LEN;
    localparam int CW     = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam int TW     = (NUM_TEMPLATES > 1) ? $clog2(NUM_TEMPLATES) : 1;
    localparam int NW     = (TEMPLATE_LEN > 1) ? $clog2(TEMPLATE_LEN) : 1;
    localparam int CHW    = $clog2(NCH);
    localparam int SQ_IT  = SUMSQ_W / 2;
    localparam int SIW    = $clog2(SQ_IT);

    bstate_t st_reg, st_next;

    logic [COST_W-1:0] col_reg [0:NCELL-1];
    logic [6:0]        scnt_reg;
    logic              ovf_reg;
    logic [TW-1:0]     t_reg;
    logic [NW-1:0]     n_reg;
    logic [CW-1:0]     cell_reg;
    logic [CHW-1:0]    ch_reg;
    logic [SUMSQ_W-1:0] acc_reg;
    logic [SUMSQ_W-1:0] rem_reg;
    logic [SUMSQ_W-1:0] root_reg;
    logic [SIW-1:0]     it_reg;
    logic [COST_W-1:0] above_reg;
    logic [COST_W-1:0] score_reg;
    logic              found_reg;
    logic [1:0]        tidx_reg;
    logic [7:0]        code_reg;
    logic [COST_W-1:0] best_reg;

    // template value of the current cell and channel
    logic signed [15:0] tv;
    logic signed [16:0] diff;
    logic [33:0]        sq;
    always_comb
    begin
        tv = 16'sd0;
        for (int t = 0; t < NUM_TEMPLATES; t++)
            for (int n = 0; n < TEMPLATE_LEN; n++)
                for (int c = 0; c < NCH; c++)
                    if (t_reg == TW'(t) && n_reg == NW'(n) && ch_reg == CHW'(c))
                        tv = tmpl_val(t, n, c);
        diff = 17'(q_data.samp[ch_reg]) - 17'(tv);
        sq   = 34'($signed(diff) * $signed(diff));
    end

    // one step of the bit-pair square root
    logic [SUMSQ_W-1:0] bitv, trial;
    always_comb
    begin
        bitv  = {{(SUMSQ_W-1){1'b0}}, 1'b1} << (2 * (SQ_IT - 1 - int'(it_reg)));
        trial = root_reg + bitv;
    end

    // neighbour minimum and saturating add
    logic [COST_W-1:0] old_v, up_v, bestn;
    logic [COST_W:0]   sum;
    always_comb
    begin
        old_v = col_reg[cell_reg];
        up_v  = (n_reg == '0) ? '0 : col_reg[cell_reg - CW'(1)];
        if (scnt_reg == 7'd0)
            bestn = (n_reg == '0) ? '0 : up_v;
        else if (n_reg == '0)
            bestn = old_v;
        else
        begin
            bestn = above_reg;
            if (up_v < bestn) bestn = up_v;
            if (old_v < bestn) bestn = old_v;
        end
        sum = {1'b0, bestn} + {1'b0, root_reg[COST_W-1:0]};
    end

    logic [23:0] th_cur;
    always_comb
    begin
        case (t_reg)
            TW'(0):  th_cur = thr_a;
            TW'(1):  th_cur = (NUM_TEMPLATES > 1) ? thr_b : THR_RESET;
            TW'(2):  th_cur = (NUM_TEMPLATES > 2) ? thr_c : THR_RESET;
            default: th_cur = THR_RESET;
        endcase
    end

    logic last_n, last_t, last_ch;
    assign last_n  = (n_reg == NW'(TEMPLATE_LEN - 1));
    assign last_t  = (t_reg == TW'(NUM_TEMPLATES - 1));
    assign last_ch = (ch_reg == CHW'(NCH - 1));

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            B_IDLE: if (q_valid)
                        st_next = (scnt_reg >= 7'(MAX_SAMPLES))
                                  ? (q_data.last ? B_SCAN : B_IDLE) : B_DIFF;
            B_DIFF: if (last_ch) st_next = B_SQRT;
            B_SQRT: if (it_reg == SIW'(SQ_IT - 1)) st_next = B_UPD;
            B_UPD:  if (last_n && last_t) st_next = q_data.last ? B_SCAN : B_IDLE;
                    else st_next = B_DIFF;
            B_SCAN: if (found_reg || (last_n && last_t)) st_next = B_OUT;
            B_OUT:  st_next = B_IDLE;
            default: st_next = B_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop = 1'b0;
        done  = 1'b0;
        case (st_reg)
            B_IDLE: q_pop = q_valid && (scnt_reg >= 7'(MAX_SAMPLES)) && !q_data.last;
            B_UPD:  q_pop = last_n && last_t && !q_data.last;
            B_OUT:  begin q_pop = 1'b1; done = 1'b1; end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == B_UPD)
            col_reg[cell_reg] <= sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= B_IDLE;
            scnt_reg <= '0;
            ovf_reg  <= 1'b0;
            t_reg <= '0; n_reg <= '0; cell_reg <= '0; ch_reg <= '0; it_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            case (st_reg)
                B_IDLE:
                begin
                    t_reg <= '0; n_reg <= '0; cell_reg <= '0; ch_reg <= '0;
                    acc_reg <= '0; found_reg <= 1'b0; score_reg <= COST_MAX;
                    if (q_valid && scnt_reg >= 7'(MAX_SAMPLES))
                        ovf_reg <= 1'b1;
                end
                B_DIFF:
                begin
                    acc_reg <= acc_reg + SUMSQ_W'(sq);
                    ch_reg  <= ch_reg + CHW'(1);
                    if (last_ch)
                    begin
                        rem_reg  <= acc_reg + SUMSQ_W'(sq);
                        root_reg <= '0;
                        it_reg   <= '0;
                    end
                end
                B_SQRT:
                begin
                    if (rem_reg >= trial)
                    begin
                        rem_reg  <= rem_reg - trial;
                        root_reg <= (root_reg >> 1) + bitv;
                    end
                    else
                        root_reg <= root_reg >> 1;
                    it_reg <= it_reg + SIW'(1);
                end
                B_UPD:
                begin
                    above_reg <= old_v;
                    ch_reg    <= '0;
                    acc_reg   <= '0;
                    cell_reg  <= cell_reg + CW'(1);
                    if (last_n)
                    begin
                        n_reg <= '0;
                        t_reg <= t_reg + TW'(1);
                    end
                    else
                        n_reg <= n_reg + NW'(1);
                    if (last_n && last_t)
                    begin
                        scnt_reg  <= scnt_reg + 7'd1;
                        t_reg <= '0; cell_reg <= '0;
                    end
                end
                B_SCAN:
                begin
                    // running column minimum, threshold test at the end of each column
                    if (col_reg[cell_reg] < score_reg || last_n)
                    begin
                        if (last_n)
                        begin
                            if (!found_reg && ((col_reg[cell_reg] < score_reg)
                                 ? col_reg[cell_reg] : score_reg) < th_cur)
                            begin
                                found_reg <= 1'b1;
                                best_reg  <= (col_reg[cell_reg] < score_reg)
                                             ? col_reg[cell_reg] : score_reg;
                                tidx_reg  <= 2'(t_reg);
                                code_reg  <= (int'(t_reg) < BUILTIN) ? CODE_L : CODE_EXTRA;
                            end
                            score_reg <= COST_MAX;
                        end
                        else
                            score_reg <= col_reg[cell_reg];
                    end
                    cell_reg <= cell_reg + CW'(1);
                    if (last_n)
                    begin
                        n_reg <= '0;
                        t_reg <= t_reg + TW'(1);
                    end
                    else
                        n_reg <= n_reg + NW'(1);
                end
                B_OUT:
                begin
                    scnt_reg <= '0;
                    ovf_reg  <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // result registers; the outputs are valid in B_OUT, while done is high
    assign gesture_found   = found_reg;
    assign template_index  = found_reg ? tidx_reg : 2'd0;
    assign gesture_code    = found_reg ? code_reg : CODE_NONE;
    assign best_score      = found_reg ? best_reg : COST_MAX;
    assign sample_overflow = ovf_reg;
endmodule

### hdl/dtw_checker.sv
// Port-level checks on the gesture matcher, bound to the top level
`timescale 1ns / 1ps
module dtw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        done,
    input logic        gesture_found,
    input logic [1:0]  template_index,
    input logic [7:0]  gesture_code,
    input logic [23:0] best_score,
    input logic        pready
);
    import dtw_pkg::*;

    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe held");
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        done && !gesture_found |-> gesture_code == CODE_NONE && best_score == COST_MAX
        && template_index == 2'd0) else $error("no-match result malformed");
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        done && gesture_found |-> gesture_code != CODE_NONE)
        else $error("match carries no-match code");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
endmodule

bind dtw_gesture_matcher dtw_checker u_chk (
    .clk(clk), .rst_n(rst_n), .done(done), .gesture_found(gesture_found),
    .template_index(template_index), .gesture_code(gesture_code),
    .best_score(best_score), .pready(pready)
);

### bench/tb.sv
// Self-checking bench for the DTW gesture matcher: sample driver, result monitor, predictor
`timescale 1ns / 1ps
module tb;
    import dtw_pkg::*;

    localparam int NTPL = 3;
    localparam int TLEN = 3;
    localparam int MAXS = 64;
    localparam int NCELL = NTPL * TLEN;

    typedef struct packed {
        logic [NCH-1:0][15:0] ch;
        logic                 last;
    } imu_item_t;

    typedef struct packed {
        logic        found;
        logic [1:0]  idx;
        logic [7:0]  code;
        logic [23:0] score;
        logic        ovf;
    } verdict_t;

    // built-in gesture templates, Q8.8, [template][row][channel]
    int gest_tab [0:89] = '{
        -146, -100, 335, -302, -225, 750, 484, 428, 397, 410,
        54, -246, 90, 125, -558, 207, 489, 425, 384, 399,
        46, -238, 110, 105, -550, 253, 484, 425, 402, 412,
        -151, -233, 353, -340, -532, 776, 492, 420, 387, 420,
        67, -238, 84, 151, -556, 200, 497, 443, 394, 397,
        69, -243, 84, 159, -558, 195, 497, 430, 407, 399,
        -128, -261, 148, -297, -653, 387, 494, 440, 387, 399,
        61, -212, 90, 141, -481, 207, 499, 425, 404, 412,
        59, -238, 90, 136, -540, 200, 486, 433, 410, 397};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        done;
    logic        gesture_found;
    logic [1:0]  template_index;
    logic [7:0]  gesture_code;
    logic [23:0] best_score;
    logic        sample_overflow;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    imu_item_t   cur = '0;
    imu_item_t   pend_q [$];
    verdict_t    verdict_q [$];

    // predictor state
    logic [23:0] cost [NCELL];
    int          seen_cnt = 0;
    bit          ovf_flag = 0;
    logic [23:0] thr [NTPL] = '{THR_RESET, THR_RESET, THR_RESET};

    int          errors = 0;
    int          taken_cnt = 0;
    int          gap = 0;
    bit          quiet = 0;

    always #10 clk = ~clk;

    dtw_gesture_matcher dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .imu_ch0(cur.ch[0]), .imu_ch1(cur.ch[1]), .imu_ch2(cur.ch[2]),
        .imu_ch6(cur.ch[3]), .imu_ch7(cur.ch[4]), .imu_ch8(cur.ch[5]),
        .imu_ch9(cur.ch[6]), .imu_ch10(cur.ch[7]), .imu_ch11(cur.ch[8]),
        .imu_ch12(cur.ch[9]), .last_sample(cur.last),
        .done(done), .gesture_found(gesture_found), .template_index(template_index),
        .gesture_code(gesture_code), .best_score(best_score),
        .sample_overflow(sample_overflow),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned cell_dist(input imu_item_t it, input int t, input int n);
        longint unsigned acc;
        longint d;
        acc = 0;
        for (int c = 0; c < NCH; c++)
        begin
            d = longint'($signed(it.ch[c])) - longint'(gest_tab[(t * 3 + n) * NCH + c]);
            acc += longint'(d * d);
        end
        return int_sqrt(acc);
    endfunction

    // advance every template column by one sample unless MAXS is reached; queue the verdict on a last sample
    function automatic void score_sample(input imu_item_t it);
        logic [23:0] old, best, above, score;
        longint unsigned sum;
        verdict_t v;
        if (seen_cnt >= MAXS)
            ovf_flag = 1;
        else
        begin
            for (int t = 0; t < NTPL; t++)
            begin
                above = '0;
                for (int n = 0; n < TLEN; n++)
                begin
                    old = cost[t * TLEN + n];
                    if (seen_cnt == 0)
                        best = (n == 0) ? 24'd0 : cost[t * TLEN + n - 1];
                    else if (n == 0)
                        best = old;
                    else
                    begin
                        best = above;
                        if (cost[t * TLEN + n - 1] < best) best = cost[t * TLEN + n - 1];
                        if (old < best) best = old;
                    end
                    sum = cell_dist(it, t, n) + best;
                    cost[t * TLEN + n] = (sum > COST_MAX) ? COST_MAX : sum[23:0];
                    above = old;
                end
            end
            seen_cnt++;
        end
        if (it.last)
        begin
            v = '{1'b0, 2'd0, CODE_NONE, COST_MAX, ovf_flag};
            for (int t = 0; t < NTPL; t++)
            begin
                score = COST_MAX;
                for (int n = 0; n < TLEN; n++)
                    if (cost[t * TLEN + n] < score) score = cost[t * TLEN + n];
                if (score < thr[t] && !v.found)
                begin
                    v.found = 1'b1;
                    v.idx = t[1:0];
                    v.code = CODE_L;
                    v.score = score;
                end
            end
            verdict_q.push_back(v);
            seen_cnt = 0;
            ovf_flag = 0;
        end
    endfunction

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        bit nxt;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            nxt = start;
            if (start && !busy)
            begin
                score_sample(cur);
                taken_cnt++;
                nxt = 0;
            end
            if (!nxt)
            begin
                if (gap > 0)
                    gap--;
                else if (pend_q.size() > 0)
                begin
                    if (!quiet && $urandom_range(0, 9) == 0)
                        gap = $urandom_range(1, 16);
                    else
                    begin
                        cur <= pend_q.pop_front();
                        nxt = 1;
                    end
                end
            end
            start <= nxt;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result monitor
    always @(posedge clk)
    begin
        verdict_t w;
        if (rst_n && done)
        begin
            if (verdict_q.size() == 0)
                report("unexpected result", 1, 0);
            else
            begin
                w = verdict_q.pop_front();
                if (gesture_found !== w.found) report("gesture_found", gesture_found, w.found);
                if (template_index !== w.idx) report("template_index", template_index, w.idx);
                if (gesture_code !== w.code) report("gesture_code", gesture_code, w.code);
                if (best_score !== w.score) report("best_score", best_score, w.score);
                if (sample_overflow !== w.ovf)
                    report("sample_overflow", sample_overflow, w.ovf);
            end
        end
    end

    // register write over the config port: a setup phase, then an access phase with penable high
    task automatic reg_write(input int idx, input logic [23:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(idx * 4);
        pwdata <= {8'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx < NTPL) thr[idx] = val;
    endtask

    task automatic drain();
        while (pend_q.size() > 0 || start || verdict_q.size() > 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
    endtask

    function automatic imu_item_t flat_item(input logic [15:0] v, input bit last);
        imu_item_t it;
        for (int c = 0; c < NCH; c++) it.ch[c] = v;
        it.last = last;
        return it;
    endfunction

    // one sample near template row t/n, or pure noise when t is out of range
    function automatic imu_item_t near_item(input int t, input int n, input int noise,
                                            input bit last);
        imu_item_t it;
        int v;
        for (int c = 0; c < NCH; c++)
        begin
            if (t < NTPL)
            begin
                v = gest_tab[(t * 3 + n) * NCH + c] + $urandom_range(0, 2 * noise) - noise;
                it.ch[c] = 16'(v);
            end
            else
                it.ch[c] = 16'($urandom);
        end
        it.last = last;
        return it;
    endfunction

    // push one gesture recording of len samples
    function automatic void push_gesture(input int t, input int len, input int noise);
        for (int k = 0; k < len; k++)
            pend_q.push_back(near_item(t, (k * TLEN) / len, noise, k == len - 1));
    endfunction

    initial
    begin
        logic [23:0] sets [5][3];
        int len;
        sets = '{'{24'd0, 24'd0, 24'd0}, '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF},
                 '{24'd300, 24'd2000, 24'hFFFFFF}, '{24'd1, 24'd6400, 24'd50000},
                 '{THR_RESET, THR_RESET, THR_RESET}};
        for (int i = 0; i < NCELL; i++) cost[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, single-sample recordings, exact template matches, noisy short gestures
        pend_q.push_back(flat_item(16'h8000, 1));
        pend_q.push_back(flat_item(16'h7FFF, 1));
        pend_q.push_back(flat_item(16'h0000, 1));
        pend_q.push_back(flat_item(16'h8000, 0));
        pend_q.push_back(flat_item(16'h7FFF, 0));
        pend_q.push_back(flat_item(16'hFFFF, 1));
        for (int t = 0; t < NTPL; t++) push_gesture(t, 3, 0);
        push_gesture(1, 5, 8);
        push_gesture(2, 2, 8);
        drain();

        // random phases across threshold settings
        for (int p = 0; p < 5; p++)
        begin
            for (int r = 0; r < NTPL; r++) reg_write(r, sets[p][r]);
            reg_write(3, 24'h123456);
            if (p == 4) quiet = 0;
            while (pend_q.size() < 165)
            begin
                if ($urandom_range(0, 24) == 0)
                    len = $urandom_range(MAXS - 1, MAXS + 6);
                else
                    len = $urandom_range(1, 7);
                push_gesture($urandom_range(0, 4), len, $urandom_range(0, 80));
            end
            if (p == 4)
            begin
                while (taken_cnt < 780 && pend_q.size() > 0) @(posedge clk);
                quiet = 1;
            end
            drain();
        end

        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("tb: FAIL");
        $finish;
    end
endmodule
